@@ design/rbsi_pkg.sv @@
// Package for the ray/box slab intersection core: widths, register map, pipeline payloads.
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int REM_W     = COORD_W;
  localparam int QUO_W     = COORD_W + FRAC_BITS;
  localparam int T_BITS    = 48;
  localparam int CMP_W     = (QUO_W > T_BITS) ? QUO_W : T_BITS;
  localparam int EXT_W     = T_BITS + 1;
  localparam logic [CMP_W-1:0] T_SAT = CMP_W'((64'd1 << (T_BITS - 1)) - 64'd1);

  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

  // One divider lane: partial remainder and dividend/quotient shift word.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } lane_t;

  // Lanes 2a and 2a+1 carry the min and max plane of axis a.
  typedef struct packed {
    lane_t [5:0]              lane;
    logic  [2:0][COORD_W-1:0] dm;
    logic  [5:0]              neg;
    logic  [2:0]              zero;
    logic  [2:0]              in_slab;
  } slab_t;

  typedef struct packed {
    logic [2:0][EXT_W-1:0] lo;
    logic [2:0][EXT_W-1:0] hi;
    logic [2:0]            zero;
    logic [2:0]            in_slab;
  } span_t;

  typedef struct packed {
    logic valid;
    logic hold;
  } flow_t;

endpackage

@@ design/rbsi_if.sv @@
// Stream interfaces: ray input channel and hit result channel.
interface rbsi_ray_if;
  logic                                valid;
  logic                                ready;
  logic signed [rbsi_pkg::COORD_W-1:0] origin_x;
  logic signed [rbsi_pkg::COORD_W-1:0] origin_y;
  logic signed [rbsi_pkg::COORD_W-1:0] origin_z;
  logic signed [rbsi_pkg::COORD_W-1:0] dir_x;
  logic signed [rbsi_pkg::COORD_W-1:0] dir_y;
  logic signed [rbsi_pkg::COORD_W-1:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rbsi_hit_if;
  logic valid;
  logic ready;
  logic hit;
  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

@@ design/ray_box_slab_intersect_core.sv @@
// Top level: ray/box slab intersection with APB box registers and a divider cell chain.
// Pipeline from ray transaction to hit transaction, in order:
//   one entry stage, one divider cell per quotient bit, one ordering stage, one result stage.
// Throughput: one ray per cycle unless stalled; a stage holds only while it is full and its
//   successor is held, so rays still enter empty stages while a result waits.
// Reset (rst, synchronous): all stage valid bits clear and the six box registers read zero.
module ray_box_slab_intersect_core (
  input  logic                           clk,
  input  logic                           rst,
  rbsi_ray_if.sink                       ray,
  rbsi_hit_if.source                     res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbsi_pkg::PADDR_W-1:0]   paddr,
  input  logic [rbsi_pkg::PDATA_W-1:0]   pwdata,
  output logic [rbsi_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int NSTEP = rbsi_pkg::QUO_W;

  // ---------------------------------------------------------------- registers
  logic signed [rbsi_pkg::COORD_W-1:0] box_min [3];
  logic signed [rbsi_pkg::COORD_W-1:0] box_max [3];
  logic [2:0]                          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_min[a] <= '0;
        box_max[a] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        rbsi_pkg::REG_BOX_MIN_X: box_min[0] <= pwdata;
        rbsi_pkg::REG_BOX_MIN_Y: box_min[1] <= pwdata;
        rbsi_pkg::REG_BOX_MIN_Z: box_min[2] <= pwdata;
        rbsi_pkg::REG_BOX_MAX_X: box_max[0] <= pwdata;
        rbsi_pkg::REG_BOX_MAX_Y: box_max[1] <= pwdata;
        rbsi_pkg::REG_BOX_MAX_Z: box_max[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rbsi_pkg::REG_BOX_MIN_X: prdata = box_min[0];
      rbsi_pkg::REG_BOX_MIN_Y: prdata = box_min[1];
      rbsi_pkg::REG_BOX_MIN_Z: prdata = box_min[2];
      rbsi_pkg::REG_BOX_MAX_X: prdata = box_max[0];
      rbsi_pkg::REG_BOX_MAX_Y: prdata = box_max[1];
      rbsi_pkg::REG_BOX_MAX_Z: prdata = box_max[2];
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- chain wiring
  // chain_hold[k+1] is the hold of divider cell k; the last entry is the ordering stage's.
  rbsi_pkg::slab_t chain_data [NSTEP+1];
  logic            chain_valid [NSTEP+1];
  logic            chain_hold  [NSTEP+2];

  // ---------------------------------------------------------------- entry stage
  // Plane distances, magnitudes and signs for the dividers; zero-direction slab test.
  rbsi_pkg::slab_t s0_next;
  rbsi_pkg::slab_t s0_data;
  logic            s0_valid;
  logic            s0_en;

  always_comb begin
    logic signed [rbsi_pkg::COORD_W-1:0] o [3];
    logic signed [rbsi_pkg::COORD_W-1:0] d [3];
    logic signed [rbsi_pkg::COORD_W:0]   num [2];
    logic        [rbsi_pkg::COORD_W:0]   mag;
    o[0] = ray.origin_x; o[1] = ray.origin_y; o[2] = ray.origin_z;
    d[0] = ray.dir_x;    d[1] = ray.dir_y;    d[2] = ray.dir_z;
    for (int a = 0; a < 3; a++) begin
      num[0] = (rbsi_pkg::COORD_W+1)'(box_min[a]) - (rbsi_pkg::COORD_W+1)'(o[a]);
      num[1] = (rbsi_pkg::COORD_W+1)'(box_max[a]) - (rbsi_pkg::COORD_W+1)'(o[a]);
      for (int s = 0; s < 2; s++) begin
        mag = num[s][rbsi_pkg::COORD_W] ? -num[s] : num[s];
        s0_next.lane[2*a+s].rem = '0;
        s0_next.lane[2*a+s].quo =
          rbsi_pkg::QUO_W'(mag[rbsi_pkg::COORD_W-1:0]) << rbsi_pkg::FRAC_BITS;
        s0_next.neg[2*a+s] = num[s][rbsi_pkg::COORD_W] != d[a][rbsi_pkg::COORD_W-1];
      end
      // two's complement of the most negative value is its own magnitude
      s0_next.dm[a]      = d[a][rbsi_pkg::COORD_W-1] ? -d[a] : d[a];
      s0_next.zero[a]    = (d[a] == '0);
      s0_next.in_slab[a] = !((o[a] < box_min[a]) || (o[a] > box_max[a]));
    end
  end

  assign s0_en     = !chain_hold[0];
  assign ray.ready = s0_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_en) begin
      s0_valid <= ray.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_en) begin
      s0_data <= s0_next;
    end
  end

  assign chain_data[0]  = s0_data;
  assign chain_valid[0] = s0_valid;
  assign chain_hold[0]  = s0_valid && chain_hold[1];

  // ---------------------------------------------------------------- divider cells
  // One quotient bit per cell, most significant first.
  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    rbsi_pkg::flow_t flow;
    rbsi_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_data   (chain_data[k]),
      .down_hold (chain_hold[k+2]),
      .flow      (flow),
      .out_data  (chain_data[k+1])
    );
    assign chain_valid[k+1] = flow.valid;
    assign chain_hold[k+1]  = flow.hold;
  end

  // ---------------------------------------------------------------- ordering stage
  rbsi_pkg::flow_t ord_flow;
  rbsi_pkg::span_t ord_data;
  logic            out_hold;

  assign out_hold = res.valid && !res.ready;

  rbsi_order_cell u_order (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[NSTEP]),
    .in_data   (chain_data[NSTEP]),
    .down_hold (out_hold),
    .flow      (ord_flow),
    .out_data  (ord_data)
  );

  assign chain_hold[NSTEP+1] = ord_flow.hold;

  // ---------------------------------------------------------------- result stage
  // Hit when every zero-direction axis has the origin inside its slab and every
  // entry bound is not past any exit bound.
  logic hit_next;
  logic res_en;

  always_comb begin
    hit_next = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (ord_data.zero[a] && !ord_data.in_slab[a]) begin
        hit_next = 1'b0;
      end
      for (int b = 0; b < 3; b++) begin
        if ($signed(ord_data.lo[a]) > $signed(ord_data.hi[b])) begin
          hit_next = 1'b0;
        end
      end
    end
  end

  assign res_en = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_en) begin
      res.valid <= ord_flow.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      res.hit <= hit_next;
    end
  end

endmodule

@@ design/rbsi_div_cell.sv @@
// One restoring-division step for all six plane lanes, with a pipeline register.
module rbsi_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rbsi_pkg::slab_t     in_data,
  input  logic                down_hold,
  output rbsi_pkg::flow_t     flow,
  output rbsi_pkg::slab_t     out_data
);

  logic            valid;
  rbsi_pkg::slab_t data_next;
  logic            en;

  always_comb begin
    logic [rbsi_pkg::REM_W:0] t;
    logic [rbsi_pkg::REM_W:0] dmx;
    logic [rbsi_pkg::REM_W:0] diff;
    logic                     ge;
    data_next = in_data;
    for (int k = 0; k < 6; k++) begin
      t    = {in_data.lane[k].rem, in_data.lane[k].quo[rbsi_pkg::QUO_W-1]};
      dmx  = {1'b0, in_data.dm[k/2]};
      diff = t - dmx;
      ge   = (t >= dmx);
      data_next.lane[k].rem = ge ? diff[rbsi_pkg::REM_W-1:0] : t[rbsi_pkg::REM_W-1:0];
      data_next.lane[k].quo = {in_data.lane[k].quo[rbsi_pkg::QUO_W-2:0], ge};
    end
  end

  assign en         = !valid || !down_hold;
  assign flow.valid = valid;
  assign flow.hold  = valid && down_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

@@ design/rbsi_order_cell.sv @@
// Saturates, signs, orders axis pairs to entry/exit; zero-dir axes get widest.
module rbsi_order_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rbsi_pkg::slab_t     in_data,
  input  logic                down_hold,
  output rbsi_pkg::flow_t     flow,
  output rbsi_pkg::span_t     out_data
);

  logic            valid;
  rbsi_pkg::span_t data_next;
  logic            en;

  always_comb begin
    logic [rbsi_pkg::CMP_W-1:0]    qz;
    logic [rbsi_pkg::T_BITS-2:0]   mag;
    logic [rbsi_pkg::EXT_W-1:0]    v [6];
    for (int k = 0; k < 6; k++) begin
      qz   = rbsi_pkg::CMP_W'(in_data.lane[k].quo);
      mag  = (qz > rbsi_pkg::T_SAT) ? rbsi_pkg::T_SAT[rbsi_pkg::T_BITS-2:0]
                                    : qz[rbsi_pkg::T_BITS-2:0];
      v[k] = in_data.neg[k] ? -rbsi_pkg::EXT_W'(mag) : rbsi_pkg::EXT_W'(mag);
    end
    data_next.zero    = in_data.zero;
    data_next.in_slab = in_data.in_slab;
    for (int a = 0; a < 3; a++) begin
      if (in_data.zero[a]) begin
        // unconstrained axis: widest interval
        data_next.lo[a] = {1'b1, {(rbsi_pkg::EXT_W-1){1'b0}}};
        data_next.hi[a] = {1'b0, {(rbsi_pkg::EXT_W-1){1'b1}}};
      end else if ($signed(v[2*a]) > $signed(v[2*a+1])) begin
        data_next.lo[a] = v[2*a+1];
        data_next.hi[a] = v[2*a];
      end else begin
        data_next.lo[a] = v[2*a];
        data_next.hi[a] = v[2*a+1];
      end
    end
  end

  assign en         = !valid || !down_hold;
  assign flow.valid = valid;
  assign flow.hold  = valid && down_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule
